### rtl/rme_pkg.sv
// Shared types, widths and constants of the rotation matrix to Euler angle pipeline.
package rme_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ANGLE_BITS = 16;
    localparam int DATA_W     = 16;

    // Front end: numerators, first square root, divider.
    localparam int NUM_W   = 17;
    localparam int T_W     = 19;
    localparam int SQ_IN_W = 32;
    localparam int RT_W    = SQ_IN_W / 2;
    localparam int QUO_W   = 15;
    localparam int DIVN_W  = 31;
    localparam int DIVD_W  = RT_W + 1;

    // Angle stage: products, atan2 arguments, second square root.
    localparam int PROD_W  = 2 * DATA_W;
    localparam int ARG_W   = 34;
    localparam int AV_W    = 2 * FRAC_BITS + 1;
    localparam int PRAD_W  = 60;
    localparam int PROOT_W = PRAD_W / 2;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // Which quaternion component is formed from the square root.
    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } branch_t;

    typedef struct packed {
        logic signed [NUM_W-1:0] n0;
        logic signed [NUM_W-1:0] n1;
        logic signed [NUM_W-1:0] n2;
        branch_t                 br;
    } sqrt_side_t;

    typedef struct packed {
        logic [2:0]       neg;
        logic [2:0]       sat;
        logic [QUO_W-1:0] lead;
        branch_t          br;
        logic             deg;
    } div_side_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] w;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } quat_t;

    typedef struct packed {
        logic signed [ARG_W-1:0] yaw_y;
        logic signed [ARG_W-1:0] yaw_x;
        logic signed [ARG_W-1:0] roll_y;
        logic signed [ARG_W-1:0] roll_x;
        logic                    vneg;
        logic [AV_W-1:0]         av;
        quat_t                   q;
        logic                    deg;
    } pitch_side_t;

    typedef struct packed {
        quat_t q;
        logic  deg;
    } out_side_t;

endpackage

### rtl/rotation_matrix_to_euler.sv
// Throughput: one matrix per cycle while the output is not stalled; the stages include the two
// digit-serial square roots, the restoring divider and the three parallel 32-step CORDIC lanes.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
// Reset clears the valid bits of all stages; data registers are not reset.
module rotation_matrix_to_euler
    import rme_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // yaw_angle, pitch_angle, roll_angle, quat_w, quat_x, quat_y, quat_z (16 bits each)
    output logic [111:0] m_axis_tdata,
    // degenerate
    output logic [0:0]   m_axis_tuser
);

    localparam logic signed [T_W-1:0] ONE = T_W'(1) <<< FRAC_BITS;

    logic adv;

    // Stage A: trace test and numerators.
    logic signed [DATA_W-1:0] m [9];
    logic [SQ_IN_W-1:0]       rad_a_next, rad_a_reg;
    sqrt_side_t               side_a_next, side_a_reg;
    logic                     valid_a_reg;

    // First square root.
    logic                     valid_s;
    logic [RT_W-1:0]          root_s;
    sqrt_side_t               side_s;

    // Stage B: divider set-up.
    logic [DIVN_W-1:0]        num_b_next [3];
    logic [DIVN_W-1:0]        num_b_reg  [3];
    logic [DIVD_W-1:0]        den_b_reg;
    div_side_t                side_b_next, side_b_reg;
    logic                     valid_b_reg;

    // Divider.
    logic                     valid_d;
    logic [QUO_W-1:0]         quo_d [3];
    div_side_t                side_d;

    // Stage C: quaternion.
    quat_t                    quat_c_next, quat_c_reg;
    logic                     deg_c_reg;
    logic                     valid_c_reg;

    // Angle arguments and pitch square root.
    logic                     valid_p;
    logic [PRAD_W-1:0]        rad_p;
    pitch_side_t              side_p;
    logic                     valid_r;
    logic [PROOT_W-1:0]       root_r;
    pitch_side_t              side_r;

    // CORDIC.
    logic signed [ARG_W-1:0]  cy_in [3];
    logic signed [ARG_W-1:0]  cx_in [3];
    logic                     valid_o;
    logic [ANGLE_BITS-1:0]    ang_o [3];
    out_side_t                side_o;

    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            m[k] = s_axis_tdata[k*DATA_W +: DATA_W];
        end
    end

    always_comb
    begin
        logic signed [T_W-1:0] trace;
        logic signed [T_W-1:0] t;
        trace       = T_W'(m[0]) + T_W'(m[4]) + T_W'(m[8]);
        side_a_next = '0;
        if (trace > 0)
        begin
            side_a_next.br = BR_TRACE;
            t              = ONE + trace;
            side_a_next.n0 = NUM_W'(m[7]) - NUM_W'(m[5]);
            side_a_next.n1 = NUM_W'(m[2]) - NUM_W'(m[6]);
            side_a_next.n2 = NUM_W'(m[3]) - NUM_W'(m[1]);
        end
        else if ((m[0] > m[4]) && (m[0] > m[8]))
        begin
            side_a_next.br = BR_X;
            t              = ONE + T_W'(m[0]) - T_W'(m[4]) - T_W'(m[8]);
            side_a_next.n0 = NUM_W'(m[7]) - NUM_W'(m[5]);
            side_a_next.n1 = NUM_W'(m[1]) + NUM_W'(m[3]);
            side_a_next.n2 = NUM_W'(m[2]) + NUM_W'(m[6]);
        end
        else if (m[4] > m[8])
        begin
            side_a_next.br = BR_Y;
            t              = ONE + T_W'(m[4]) - T_W'(m[0]) - T_W'(m[8]);
            side_a_next.n0 = NUM_W'(m[2]) - NUM_W'(m[6]);
            side_a_next.n1 = NUM_W'(m[1]) + NUM_W'(m[3]);
            side_a_next.n2 = NUM_W'(m[5]) + NUM_W'(m[7]);
        end
        else
        begin
            side_a_next.br = BR_Z;
            t              = ONE + T_W'(m[8]) - T_W'(m[0]) - T_W'(m[4]);
            side_a_next.n0 = NUM_W'(m[3]) - NUM_W'(m[1]);
            side_a_next.n1 = NUM_W'(m[2]) + NUM_W'(m[6]);
            side_a_next.n2 = NUM_W'(m[5]) + NUM_W'(m[7]);
        end
        // A radicand that is not positive yields a zero root, which marks the result degenerate.
        rad_a_next = (t > 0) ? (SQ_IN_W'(unsigned'(t)) << FRAC_BITS) : '0;
    end

    rme_isqrt #(
        .IN_W   (SQ_IN_W),
        .STEPS  (2),
        .SIDE_W ($bits(sqrt_side_t))
    ) u_sqrt_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_a_reg),
        .rad       (rad_a_reg),
        .in_side   (side_a_reg),
        .out_valid (valid_s),
        .root      (root_s),
        .out_side  (side_s)
    );

    always_comb
    begin
        logic signed [NUM_W-1:0] n [3];
        logic [NUM_W-1:0]        mag;
        logic [RT_W:0]           rp1;
        logic [DIVN_W:0]         lim;
        n[0]        = side_s.n0;
        n[1]        = side_s.n1;
        n[2]        = side_s.n2;
        side_b_next = '0;
        lim         = {root_s, 1'b0, {QUO_W{1'b0}}};
        for (int l = 0; l < 3; l++)
        begin
            mag                = n[l][NUM_W-1] ? NUM_W'(-n[l]) : NUM_W'(n[l]);
            num_b_next[l]      = (DIVN_W'(mag) << FRAC_BITS) + DIVN_W'(root_s);
            side_b_next.neg[l] = n[l][NUM_W-1];
            // A quotient of 2^15 or more saturates the component.
            side_b_next.sat[l] = ({1'b0, num_b_next[l]} >= lim);
        end
        rp1               = {1'b0, root_s} + {{RT_W{1'b0}}, 1'b1};
        side_b_next.lead  = rp1[QUO_W:1];
        side_b_next.br    = side_s.br;
        side_b_next.deg   = (root_s == '0);
    end

    rme_div #(
        .LANES  (3),
        .STEPS  (3),
        .SIDE_W ($bits(div_side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_b_reg),
        .num       (num_b_reg),
        .den       (den_b_reg),
        .in_side   (side_b_reg),
        .out_valid (valid_d),
        .quo       (quo_d),
        .out_side  (side_d)
    );

    always_comb
    begin
        logic signed [DATA_W-1:0] c [3];
        logic signed [DATA_W-1:0] qs;
        logic signed [DATA_W-1:0] lg;
        for (int l = 0; l < 3; l++)
        begin
            qs = $signed({1'b0, quo_d[l]});
            if (side_d.sat[l])
            begin
                c[l] = side_d.neg[l] ? 16'sh8000 : 16'sh7FFF;
            end
            else
            begin
                c[l] = side_d.neg[l] ? -qs : qs;
            end
        end
        lg = $signed({1'b0, side_d.lead});
        case (side_d.br)
            BR_TRACE:
            begin
                quat_c_next = '{w: lg, x: c[0], y: c[1], z: c[2]};
            end
            BR_X:
            begin
                quat_c_next = '{w: c[0], x: lg, y: c[1], z: c[2]};
            end
            BR_Y:
            begin
                quat_c_next = '{w: c[0], x: c[1], y: lg, z: c[2]};
            end
            default:
            begin
                quat_c_next = '{w: c[0], x: c[1], y: c[2], z: lg};
            end
        endcase
    end

    rme_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_c_reg),
        .q         (quat_c_reg),
        .deg       (deg_c_reg),
        .out_valid (valid_p),
        .rad       (rad_p),
        .out_side  (side_p)
    );

    rme_isqrt #(
        .IN_W   (PRAD_W),
        .STEPS  (3),
        .SIDE_W ($bits(pitch_side_t))
    ) u_sqrt_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_p),
        .rad       (rad_p),
        .in_side   (side_p),
        .out_valid (valid_r),
        .root      (root_r),
        .out_side  (side_r)
    );

    // Lanes: yaw, pitch, roll.
    always_comb
    begin
        logic signed [ARG_W-1:0] av;
        av       = $signed(ARG_W'(side_r.av));
        cy_in[0] = side_r.yaw_y;
        cx_in[0] = side_r.yaw_x;
        cy_in[1] = side_r.vneg ? -av : av;
        cx_in[1] = $signed(ARG_W'(root_r));
        cy_in[2] = side_r.roll_y;
        cx_in[2] = side_r.roll_x;
    end

    rme_cordic #(
        .LANES  (3),
        .STEPS  (4),
        .SIDE_W ($bits(out_side_t))
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (valid_r),
        .y_in      (cy_in),
        .x_in      (cx_in),
        .in_side   ({side_r.q, side_r.deg}),
        .out_valid (valid_o),
        .angle     (ang_o),
        .out_side  (side_o)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= s_axis_tvalid;
            valid_b_reg <= valid_s;
            valid_c_reg <= valid_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_a_reg  <= rad_a_next;
            side_a_reg <= side_a_next;
            num_b_reg  <= num_b_next;
            den_b_reg  <= {root_s, 1'b0};
            side_b_reg <= side_b_next;
            quat_c_reg <= quat_c_next;
            deg_c_reg  <= side_d.deg;
        end
    end

    assign m_axis_tvalid = valid_o;
    assign m_axis_tuser  = side_o.deg;
    assign m_axis_tdata  = side_o.deg ? '0 :
                           {side_o.q.z, side_o.q.y, side_o.q.x, side_o.q.w,
                            ang_o[2], ang_o[1], ang_o[0]};

endmodule

### rtl/rme_isqrt.sv
// Pipelined digit-by-digit integer square root with a sideband that travels alongside.
module rme_isqrt
    import rme_pkg::*;
#(
    parameter int IN_W   = 32,
    parameter int STEPS  = 2,
    parameter int SIDE_W = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [IN_W-1:0]      rad,
    input  logic [SIDE_W-1:0]    in_side,
    output logic                 out_valid,
    output logic [IN_W/2-1:0]    root,
    output logic [SIDE_W-1:0]    out_side
);

    localparam int ROOT_W = IN_W / 2;
    localparam int NSTG   = ROOT_W / STEPS;
    localparam int REM_W  = ROOT_W + 3;

    logic [REM_W-1:0]  rem_reg   [NSTG];
    logic [ROOT_W-1:0] root_reg  [NSTG];
    logic [IN_W-1:0]   rad_reg   [NSTG];
    logic [SIDE_W-1:0] side_reg  [NSTG];
    logic [NSTG-1:0]   valid_reg;

    logic [REM_W-1:0]  rem_next  [NSTG];
    logic [ROOT_W-1:0] root_next [NSTG];
    logic [IN_W-1:0]   rad_next  [NSTG];

    always_comb
    begin
        logic [REM_W-1:0]  rem_v;
        logic [ROOT_W-1:0] root_v;
        logic [IN_W-1:0]   rad_v;
        logic [REM_W-1:0]  trial;
        for (int s = 0; s < NSTG; s++)
        begin
            if (s == 0)
            begin
                rem_v  = '0;
                root_v = '0;
                rad_v  = rad;
            end
            else
            begin
                rem_v  = rem_reg[s-1];
                root_v = root_reg[s-1];
                rad_v  = rad_reg[s-1];
            end
            for (int k = 0; k < STEPS; k++)
            begin
                // Bring down the next pair of radicand bits and try 4*root+1.
                rem_v = {rem_v[REM_W-3:0], rad_v[IN_W-1 -: 2]};
                rad_v = {rad_v[IN_W-3:0], 2'b00};
                trial = {{(REM_W-ROOT_W-2){1'b0}}, root_v, 2'b01};
                if (rem_v >= trial)
                begin
                    rem_v  = rem_v - trial;
                    root_v = {root_v[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    root_v = {root_v[ROOT_W-2:0], 1'b0};
                end
            end
            rem_next[s]  = rem_v;
            root_next[s] = root_v;
            rad_next[s]  = rad_v;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
                rad_reg[s]  <= rad_next[s];
                side_reg[s] <= (s == 0) ? in_side : side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign root      = root_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

### rtl/rme_div.sv
// Pipelined restoring divider, several quotient lanes sharing one divisor.
module rme_div
    import rme_pkg::*;
#(
    parameter int LANES  = 3,
    parameter int STEPS  = 3,
    parameter int SIDE_W = 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [DIVN_W-1:0]  num [LANES],
    input  logic [DIVD_W-1:0]  den,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [QUO_W-1:0]   quo [LANES],
    output logic [SIDE_W-1:0]  out_side
);

    localparam int NSTG = QUO_W / STEPS;

    logic [DIVN_W-1:0] rem_reg  [NSTG][LANES];
    logic [QUO_W-1:0]  q_reg    [NSTG][LANES];
    logic [DIVD_W-1:0] den_reg  [NSTG];
    logic [SIDE_W-1:0] side_reg [NSTG];
    logic [NSTG-1:0]   valid_reg;

    logic [DIVN_W-1:0] rem_next [NSTG][LANES];
    logic [QUO_W-1:0]  q_next   [NSTG][LANES];

    always_comb
    begin
        logic [DIVN_W-1:0] rem_v;
        logic [QUO_W-1:0]  q_v;
        logic [DIVD_W-1:0] den_v;
        logic [DIVN_W:0]   dsh;
        int                b;
        for (int s = 0; s < NSTG; s++)
        begin
            den_v = (s == 0) ? den : den_reg[s-1];
            for (int l = 0; l < LANES; l++)
            begin
                if (s == 0)
                begin
                    rem_v = num[l];
                    q_v   = '0;
                end
                else
                begin
                    rem_v = rem_reg[s-1][l];
                    q_v   = q_reg[s-1][l];
                end
                for (int k = 0; k < STEPS; k++)
                begin
                    b   = QUO_W - 1 - (s * STEPS + k);
                    dsh = {{(DIVN_W+1-DIVD_W){1'b0}}, den_v} << b;
                    if ({1'b0, rem_v} >= dsh)
                    begin
                        rem_v  = rem_v - dsh[DIVN_W-1:0];
                        q_v[b] = 1'b1;
                    end
                end
                rem_next[s][l] = rem_v;
                q_next[s][l]   = q_v;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                den_reg[s]  <= (s == 0) ? den : den_reg[s-1];
                side_reg[s] <= (s == 0) ? in_side : side_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                end
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = q_reg[NSTG-1][l];
        end
    end

    assign out_valid = valid_reg[NSTG-1];
    assign out_side  = side_reg[NSTG-1];

endmodule

### rtl/rme_prep.sv
// Quaternion products, atan2 arguments and the pitch radicand, four register stages.
module rme_prep
    import rme_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  quat_t               q,
    input  logic                deg,
    output logic                out_valid,
    output logic [PRAD_W-1:0]   rad,
    output pitch_side_t         out_side
);

    localparam logic signed [ARG_W-1:0] ONE2  = ARG_W'(1) <<< (2 * FRAC_BITS);
    localparam logic [PRAD_W-1:0]       AO_SQ = PRAD_W'(1) << (4 * FRAC_BITS);

    logic [3:0] valid_reg;

    // Stage 1: products.
    logic signed [PROD_W-1:0] wy_reg, zx_reg, xx_reg, yy_reg, wx_reg;
    logic signed [PROD_W-1:0] yz_reg, wz_reg, xy_reg, zz_reg;
    quat_t                    q1_reg;
    logic                     deg1_reg;

    // Stage 2: atan2 arguments.
    pitch_side_t              side2_reg;
    pitch_side_t              side2_next;

    // Stage 3: square of the pitch argument.
    logic [2*AV_W-1:0]        sq_reg;
    pitch_side_t              side3_reg;

    // Stage 4: radicand.
    logic [PRAD_W-1:0]        rad_reg;
    pitch_side_t              side4_reg;

    always_comb
    begin
        logic signed [ARG_W-1:0] v;
        side2_next        = '0;
        side2_next.yaw_y  = (ARG_W'(wy_reg) + ARG_W'(zx_reg)) <<< 1;
        side2_next.yaw_x  = ONE2 - ((ARG_W'(xx_reg) + ARG_W'(yy_reg)) <<< 1);
        side2_next.roll_y = (ARG_W'(wz_reg) + ARG_W'(xy_reg)) <<< 1;
        side2_next.roll_x = ONE2 - ((ARG_W'(zz_reg) + ARG_W'(xx_reg)) <<< 1);
        v = (ARG_W'(wx_reg) - ARG_W'(yz_reg)) <<< 1;
        // The asin argument saturates to plus or minus one.
        if (v > ONE2)
        begin
            v = ONE2;
        end
        else if (v < -ONE2)
        begin
            v = -ONE2;
        end
        side2_next.vneg = v[ARG_W-1];
        side2_next.av   = v[ARG_W-1] ? AV_W'(-v) : AV_W'(v);
        side2_next.q    = q1_reg;
        side2_next.deg  = deg1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wy_reg    <= q.w * q.y;
            zx_reg    <= q.z * q.x;
            xx_reg    <= q.x * q.x;
            yy_reg    <= q.y * q.y;
            wx_reg    <= q.w * q.x;
            yz_reg    <= q.y * q.z;
            wz_reg    <= q.w * q.z;
            xy_reg    <= q.x * q.y;
            zz_reg    <= q.z * q.z;
            q1_reg    <= q;
            deg1_reg  <= deg;
            side2_reg <= side2_next;
            sq_reg    <= side2_reg.av * side2_reg.av;
            side3_reg <= side2_reg;
            rad_reg   <= AO_SQ - PRAD_W'(sq_reg);
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = valid_reg[3];
    assign rad       = rad_reg;
    assign out_side  = side4_reg;

endmodule

### rtl/rme_cordic.sv
// Pipelined vectoring CORDIC atan2 lanes, result as a rounded binary angle.
module rme_cordic
    import rme_pkg::*;
#(
    parameter int LANES  = 3,
    parameter int STEPS  = 4,
    parameter int SIDE_W = 1
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic signed [ARG_W-1:0]     y_in [LANES],
    input  logic signed [ARG_W-1:0]     x_in [LANES],
    input  logic [SIDE_W-1:0]           in_side,
    output logic                        out_valid,
    output logic [ANGLE_BITS-1:0]       angle [LANES],
    output logic [SIDE_W-1:0]           out_side
);

    localparam int ITERS = 32;
    localparam int NSTG  = ITERS / STEPS;
    localparam int CW    = ARG_W + 2;
    localparam int ZW    = 34;
    localparam logic signed [ZW-1:0] HALF_TURN = $signed({{(ZW-32){1'b0}}, 32'h8000_0000});
    localparam logic [31:0]          RND       = 32'(1) << (31 - ANGLE_BITS);

    logic signed [CW-1:0] cx_reg   [NSTG][LANES];
    logic signed [CW-1:0] cy_reg   [NSTG][LANES];
    logic signed [ZW-1:0] z_reg    [NSTG][LANES];
    logic                 xneg_reg [NSTG][LANES];
    logic                 yneg_reg [NSTG][LANES];
    logic                 zero_reg [NSTG][LANES];
    logic [SIDE_W-1:0]    side_reg [NSTG];
    logic [NSTG:0]        valid_reg;

    logic signed [CW-1:0] cx_next  [NSTG][LANES];
    logic signed [CW-1:0] cy_next  [NSTG][LANES];
    logic signed [ZW-1:0] z_next   [NSTG][LANES];

    logic [ANGLE_BITS-1:0] ang_reg  [LANES];
    logic [ANGLE_BITS-1:0] ang_next [LANES];
    logic [SIDE_W-1:0]     side_o_reg;

    always_comb
    begin
        logic signed [CW-1:0] cx_v, cy_v, dx, dy, xe, ye;
        logic signed [ZW-1:0] z_v;
        int                   i;
        for (int s = 0; s < NSTG; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                if (s == 0)
                begin
                    xe   = CW'(x_in[l]);
                    ye   = CW'(y_in[l]);
                    cx_v = xe[CW-1] ? -xe : xe;
                    cy_v = ye[CW-1] ? -ye : ye;
                    z_v  = '0;
                end
                else
                begin
                    cx_v = cx_reg[s-1][l];
                    cy_v = cy_reg[s-1][l];
                    z_v  = z_reg[s-1][l];
                end
                for (int k = 0; k < STEPS; k++)
                begin
                    i  = s * STEPS + k;
                    dx = cy_v >>> i;
                    dy = cx_v >>> i;
                    if (!cy_v[CW-1])
                    begin
                        cx_v = cx_v + dx;
                        cy_v = cy_v - dy;
                        z_v  = z_v + $signed({{(ZW-32){1'b0}}, ATAN_TAB[i[4:0]]});
                    end
                    else
                    begin
                        cx_v = cx_v - dx;
                        cy_v = cy_v + dy;
                        z_v  = z_v - $signed({{(ZW-32){1'b0}}, ATAN_TAB[i[4:0]]});
                    end
                end
                cx_next[s][l] = cx_v;
                cy_next[s][l] = cy_v;
                z_next[s][l]  = z_v;
            end
        end
    end

    // Restore the quadrant from the input signs, then round to the angle width.
    always_comb
    begin
        logic signed [ZW-1:0] z2;
        logic [31:0]          zu;
        for (int l = 0; l < LANES; l++)
        begin
            z2 = xneg_reg[NSTG-1][l] ? (HALF_TURN - z_reg[NSTG-1][l]) : z_reg[NSTG-1][l];
            z2 = yneg_reg[NSTG-1][l] ? -z2 : z2;
            if (zero_reg[NSTG-1][l])
            begin
                z2 = '0;
            end
            zu          = z2[31:0] + RND;
            ang_next[l] = zu[31 -: ANGLE_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTG-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < NSTG; s++)
            begin
                side_reg[s] <= (s == 0) ? in_side : side_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    cx_reg[s][l] <= cx_next[s][l];
                    cy_reg[s][l] <= cy_next[s][l];
                    z_reg[s][l]  <= z_next[s][l];
                    if (s == 0)
                    begin
                        xneg_reg[s][l] <= x_in[l][ARG_W-1];
                        yneg_reg[s][l] <= y_in[l][ARG_W-1];
                        zero_reg[s][l] <= (x_in[l] == '0) && (y_in[l] == '0);
                    end
                    else
                    begin
                        xneg_reg[s][l] <= xneg_reg[s-1][l];
                        yneg_reg[s][l] <= yneg_reg[s-1][l];
                        zero_reg[s][l] <= zero_reg[s-1][l];
                    end
                end
            end
            for (int l = 0; l < LANES; l++)
            begin
                ang_reg[l] <= ang_next[l];
            end
            side_o_reg <= side_reg[NSTG-1];
        end
    end

    assign out_valid = valid_reg[NSTG];
    assign angle     = ang_reg;
    assign out_side  = side_o_reg;

endmodule

### rtl/rme_checker.sv
// Port-level checker for the rotation matrix to Euler angle block, with its bind.
module rme_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);

    // A stalled output transaction stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output transaction dropped while stalled");

    // A stalled output payload holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output payload changed while stalled");

    // A degenerate result carries all-zero fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate result with nonzero fields");

    // Pitch comes from asin and stays within a quarter turn.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[31:16]) <= 16'sd16384)
                       && ($signed(m_axis_tdata[31:16]) >= -16'sd16384))
        else $error("pitch outside a quarter turn");

endmodule

bind rotation_matrix_to_euler rme_checker u_rme_checker (.*);
